// ===== hw/rtl/sufs_pkg.sv =====
// ----------------------------------------------------------------------------
// sufs_pkg
// Shared constants, types and arithmetic helpers for the stereo upmix block
// with FIR surround channels.
// ----------------------------------------------------------------------------
package sufs_pkg;

  // Sample and delay line geometry
  localparam int SAMPLE_BITS = 24;
  localparam int TAP_COUNT   = 31;
  localparam int PTR_W       = $clog2(TAP_COUNT);
  localparam int FILL_W      = $clog2(TAP_COUNT + 1);
  localparam int ADDR_W      = PTR_W + 1;

  // Configuration field widths
  localparam int GAIN_W      = 16;
  localparam int MODE_W      = 2;
  localparam int THR_W       = 23;
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;
  localparam int REG_IDX_W   = 2;

  // Fixed point formats
  localparam int GAIN_FRAC   = 14;
  localparam int COEF_FRAC   = 23;
  localparam int COEF_W      = 24;
  localparam int MUL_B_W     = (COEF_W > GAIN_W + 1) ? COEF_W : GAIN_W + 1;
  localparam int PROD_W      = SAMPLE_BITS + MUL_B_W;
  localparam int ACC_W       = PROD_W + PTR_W;
  localparam int CLIP_W      = SAMPLE_BITS + 2;

  localparam logic signed [ACC_W-1:0] ACC_SMP_MAX =
    ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] ACC_SMP_MIN = -ACC_SMP_MAX - ACC_W'(1);

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_GAIN = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MODE = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CLIP = 2'd2;

  // Output modes; the unused code behaves as stereo passthrough
  localparam logic [MODE_W-1:0] MODE_STEREO = 2'd0;
  localparam logic [MODE_W-1:0] MODE_220    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_321    = 2'd2;

  // Reset values of the registers
  localparam logic [GAIN_W-1:0] GAIN_RST = 16'd16384;
  localparam logic [MODE_W-1:0] MODE_RST = MODE_321;
  localparam logic [THR_W-1:0]  CLIP_RST = 23'd8388607;

  // Accumulator control from the sequencer to the MAC
  typedef struct packed {
    logic acc_en;
    logic acc_clr;
  } mac_ctl_t;

  // Symmetric high-pass taps, Q1.23; taps past the table read zero
  function automatic logic signed [COEF_W-1:0] coef_at(input logic [PTR_W-1:0] k);
    logic signed [COEF_W-1:0] c;
    case (int'(k))
      0, 30:   c = -24'sd78055;
      1, 29:   c = -24'sd79192;
      2, 28:   c = -24'sd80279;
      3, 27:   c = -24'sd81313;
      4, 26:   c = -24'sd82290;
      5, 25:   c = -24'sd83205;
      6, 24:   c = -24'sd84055;
      7, 23:   c = -24'sd84835;
      8, 22:   c = -24'sd85540;
      9, 21:   c = -24'sd86166;
      10, 20:  c = -24'sd86708;
      11, 19:  c = -24'sd87163;
      12, 18:  c = -24'sd87524;
      13, 17:  c = -24'sd87788;
      14, 16:  c = -24'sd87949;
      15:      c = 24'sd8223130;
      default: c = '0;
    endcase
    return c;
  endfunction

  // Round half up at the given fraction point, then saturate to a sample
  function automatic logic signed [SAMPLE_BITS-1:0] sat_round(
    input logic signed [ACC_W-1:0] v,
    input int unsigned             frac
  );
    logic signed [ACC_W-1:0] half;
    logic signed [ACC_W-1:0] sh;
    logic signed [ACC_W-1:0] res;
    half = ACC_W'(1) << (frac - 1);
    sh   = (v + half) >>> frac;
    if (sh > ACC_SMP_MAX) begin
      res = ACC_SMP_MAX;
    end else if (sh < ACC_SMP_MIN) begin
      res = ACC_SMP_MIN;
    end else begin
      res = sh;
    end
    return SAMPLE_BITS'(res);
  endfunction

  // Sum two samples and limit to +/- threshold
  function automatic logic signed [SAMPLE_BITS-1:0] clip_sum(
    input logic signed [SAMPLE_BITS-1:0] a,
    input logic signed [SAMPLE_BITS-1:0] b,
    input logic        [THR_W-1:0]       thr
  );
    logic signed [CLIP_W-1:0] s;
    logic signed [CLIP_W-1:0] t;
    logic signed [CLIP_W-1:0] res;
    s = CLIP_W'(a) + CLIP_W'(b);
    t = $signed(CLIP_W'(thr));
    if (s > t) begin
      res = t;
    end else if (s < -t) begin
      res = -t;
    end else begin
      res = s;
    end
    return SAMPLE_BITS'(res);
  endfunction

endpackage

// ===== hw/rtl/sufs_dmem.sv =====
// ----------------------------------------------------------------------------
// sufs_dmem
// Delay line storage for both channels: one write port, one read port with a
// registered read. Left entries sit in the lower half, right in the upper.
// ----------------------------------------------------------------------------
module sufs_dmem (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic        [sufs_pkg::ADDR_W-1:0]      waddr_i,
  input  logic signed [sufs_pkg::SAMPLE_BITS-1:0] wdata_i,
  input  logic        [sufs_pkg::ADDR_W-1:0]      raddr_i,
  output logic signed [sufs_pkg::SAMPLE_BITS-1:0] rdata_o
);

  logic signed [sufs_pkg::SAMPLE_BITS-1:0] mem [2**sufs_pkg::ADDR_W];
  logic signed [sufs_pkg::SAMPLE_BITS-1:0] rdata_q;

  // Write the new sample
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Register the read word
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/sufs_mac.sv =====
// ----------------------------------------------------------------------------
// sufs_mac
// Shared multiply-accumulate unit: a registered signed product followed by a
// wide accumulator that restarts on the first tap of each channel.
// ----------------------------------------------------------------------------
module sufs_mac (
  input  logic                                    clk_i,
  input  logic signed [sufs_pkg::SAMPLE_BITS-1:0] mul_a_i,
  input  logic signed [sufs_pkg::MUL_B_W-1:0]     mul_b_i,
  input  sufs_pkg::mac_ctl_t                      ctl_i,
  output logic signed [sufs_pkg::PROD_W-1:0]      prod_o,
  output logic signed [sufs_pkg::ACC_W-1:0]       acc_o
);

  logic signed [sufs_pkg::PROD_W-1:0] prod_d, prod_q;
  logic signed [sufs_pkg::ACC_W-1:0]  acc_d, acc_q;

  // Multiply
  assign prod_d = mul_a_i * mul_b_i;

  // Accumulate, restarting on the first product of a channel
  always_comb begin
    acc_d = acc_q;
    if (ctl_i.acc_en) begin
      acc_d = (ctl_i.acc_clr ? '0 : acc_q) + sufs_pkg::ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign prod_o = prod_q;
  assign acc_o  = acc_q;

endmodule

// ===== hw/rtl/stereo_upmix_fir_surround.sv =====
// ----------------------------------------------------------------------------
// stereo_upmix_fir_surround
// Stereo upmix with gain, 31-tap FIR surround channels, center and LFE.
// ----------------------------------------------------------------------------
// One stereo request is worked on at a time. Gain for both samples is worked
// out on the shared multiplier. In stereo passthrough the gained samples then
// go to the output register. In modes 2/2/0 and 3/2/1 the gained samples are
// written to the delay memory and the single MAC then walks both delay lines
// one entry per cycle through the memory's one read port, 2*TAP_COUNT reads
// in all, before the result goes to the output register. A new request is
// taken as soon as the previous result has moved into the output register,
// even while that result still waits to be taken. Delay line contents after
// reset read as zero through a fill count, so no clearing pass is needed.
// Registers sit at byte addresses 0 (input_gain), 4 (mix_mode) and 8
// (clip_threshold).
// ----------------------------------------------------------------------------
module stereo_upmix_fir_surround (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // APB-style configuration port
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic        [sufs_pkg::PADDR_W-1:0]     paddr,
  input  logic        [sufs_pkg::PDATA_W-1:0]     pwdata,
  output logic        [sufs_pkg::PDATA_W-1:0]     prdata,
  output logic                                    pready,
  // Input channel
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [sufs_pkg::SAMPLE_BITS-1:0] left_sample_i,
  input  logic signed [sufs_pkg::SAMPLE_BITS-1:0] right_sample_i,
  // Output channel
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [sufs_pkg::SAMPLE_BITS-1:0] left_surround_o,
  output logic signed [sufs_pkg::SAMPLE_BITS-1:0] left_front_o,
  output logic signed [sufs_pkg::SAMPLE_BITS-1:0] center_out_o,
  output logic signed [sufs_pkg::SAMPLE_BITS-1:0] right_front_o,
  output logic signed [sufs_pkg::SAMPLE_BITS-1:0] right_surround_o,
  output logic signed [sufs_pkg::SAMPLE_BITS-1:0] lfe_out_o,
  output logic                                    surround_valid_o,
  output logic                                    center_lfe_valid_o
);

  localparam int SB        = sufs_pkg::SAMPLE_BITS;
  localparam int FIR_ISSUE = 2 * sufs_pkg::TAP_COUNT;
  localparam int FIR_END   = FIR_ISSUE + 2;
  localparam int CNT_W     = $clog2(FIR_END + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_GAIN  = 3'd1;
  localparam logic [2:0] ST_WRITE = 3'd2;
  localparam logic [2:0] ST_FIR   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  localparam logic [sufs_pkg::PTR_W-1:0] PTR_LAST =
    sufs_pkg::PTR_W'(sufs_pkg::TAP_COUNT - 1);

  // Control state
  logic [2:0]                     state_d, state_q;
  logic [CNT_W-1:0]               cnt_d, cnt_q;
  logic [sufs_pkg::PTR_W-1:0]     ptr_d, ptr_q;
  logic [sufs_pkg::FILL_W-1:0]    fill_d, fill_q;
  logic [sufs_pkg::PTR_W-1:0]     entry_d, entry_q;
  logic [sufs_pkg::PTR_W-1:0]     cidx_d, cidx_q;
  logic                           side_d, side_q;
  logic                           s1_vld_d, s1_vld_q;
  logic                           s1_first_q, s1_last_q, s1_side_q, s1_ok_q;
  logic [sufs_pkg::PTR_W-1:0]     s1_cidx_q;
  logic                           s2_vld_q, s2_first_q, s2_last_q, s2_side_q;
  logic                           cap_q, cap_side_q;
  logic                           out_valid_d, out_valid_q;

  // Configuration registers
  logic [sufs_pkg::GAIN_W-1:0]    gain_q;
  logic [sufs_pkg::MODE_W-1:0]    mode_q;
  logic [sufs_pkg::THR_W-1:0]     thr_q;

  // Payload registers
  logic signed [SB-1:0]           l_raw_q, r_raw_q;
  logic signed [SB-1:0]           l_gain_d, l_gain_q, r_gain_d, r_gain_q;
  logic signed [SB-1:0]           ls_d, ls_q, rs_d, rs_q;
  logic signed [SB-1:0]           o_ls_q, o_lf_q, o_c_q, o_rf_q, o_rs_q, o_lfe_q;
  logic                           o_sv_q, o_clv_q;

  // Datapath wires
  logic                              in_acc, out_load, filt, full, issue;
  logic                              cfg_wr;
  logic [sufs_pkg::REG_IDX_W-1:0]    reg_idx;
  logic                              mem_we;
  logic [sufs_pkg::ADDR_W-1:0]       mem_waddr, mem_raddr;
  logic signed [SB-1:0]              mem_wdata, mem_rdata;
  logic signed [SB-1:0]              mul_a;
  logic signed [sufs_pkg::MUL_B_W-1:0] mul_b;
  logic signed [sufs_pkg::PROD_W-1:0]  prod;
  logic signed [sufs_pkg::ACC_W-1:0]   acc;
  sufs_pkg::mac_ctl_t                mac_ctl;

  // Configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[sufs_pkg::PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      sufs_pkg::REG_GAIN: prdata = sufs_pkg::PDATA_W'(gain_q);
      sufs_pkg::REG_MODE: prdata = sufs_pkg::PDATA_W'(mode_q);
      sufs_pkg::REG_CLIP: prdata = sufs_pkg::PDATA_W'(thr_q);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= sufs_pkg::GAIN_RST;
      mode_q <= sufs_pkg::MODE_RST;
      thr_q  <= sufs_pkg::CLIP_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        sufs_pkg::REG_GAIN: gain_q <= pwdata[sufs_pkg::GAIN_W-1:0];
        sufs_pkg::REG_MODE: mode_q <= pwdata[sufs_pkg::MODE_W-1:0];
        sufs_pkg::REG_CLIP: thr_q  <= pwdata[sufs_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshakes and mode decode
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);
  assign filt       = mode_q inside {sufs_pkg::MODE_220, sufs_pkg::MODE_321};
  assign full       = (mode_q == sufs_pkg::MODE_321);
  assign issue      = (state_q == ST_FIR) && (cnt_q < CNT_W'(FIR_ISSUE));

  // Sequencer: gain, in the filter modes write and walk both lines, hand off the result
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q + CNT_W'(1);
    ptr_d    = ptr_q;
    fill_d   = fill_q;
    entry_d  = entry_q;
    cidx_d   = cidx_q;
    side_d   = side_q;
    l_gain_d = l_gain_q;
    r_gain_d = r_gain_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_acc) begin
          state_d = ST_GAIN;
        end
      end
      ST_GAIN: begin
        if (cnt_q == CNT_W'(1)) begin
          l_gain_d = sufs_pkg::sat_round(sufs_pkg::ACC_W'(prod), sufs_pkg::GAIN_FRAC);
        end
        if (cnt_q == CNT_W'(2)) begin
          r_gain_d = sufs_pkg::sat_round(sufs_pkg::ACC_W'(prod), sufs_pkg::GAIN_FRAC);
          cnt_d    = '0;
          state_d  = filt ? ST_WRITE : ST_OUT;
        end
      end
      ST_WRITE: begin
        if (cnt_q == CNT_W'(1)) begin
          // Advance the pointer and count filled entries up to the line length
          ptr_d   = (ptr_q == PTR_LAST) ? '0 : ptr_q + sufs_pkg::PTR_W'(1);
          fill_d  = (fill_q == sufs_pkg::FILL_W'(sufs_pkg::TAP_COUNT)) ?
                    fill_q : fill_q + sufs_pkg::FILL_W'(1);
          entry_d = ptr_d;
          cidx_d  = PTR_LAST;
          side_d  = 1'b0;
          cnt_d   = '0;
          state_d = ST_FIR;
        end
      end
      ST_FIR: begin
        if (issue) begin
          if (cidx_q == '0) begin
            cidx_d  = PTR_LAST;
            entry_d = ptr_q;
            side_d  = 1'b1;
          end else begin
            cidx_d  = cidx_q - sufs_pkg::PTR_W'(1);
            entry_d = (entry_q == PTR_LAST) ? '0 : entry_q + sufs_pkg::PTR_W'(1);
          end
        end
        if (cnt_q == CNT_W'(FIR_END)) begin
          cnt_d   = '0;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        cnt_d = '0;
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        cnt_d   = '0;
        state_d = ST_IDLE;
      end
    endcase
  end

  assign s1_vld_d = issue;

  // Capture finished FIR sums
  always_comb begin
    ls_d = ls_q;
    rs_d = rs_q;
    if (cap_q) begin
      if (cap_side_q) begin
        rs_d = sufs_pkg::sat_round(acc, sufs_pkg::COEF_FRAC);
      end else begin
        ls_d = sufs_pkg::sat_round(acc, sufs_pkg::COEF_FRAC);
      end
    end
  end

  // Output register handoff
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      ptr_q       <= '0;
      fill_q      <= '0;
      entry_q     <= '0;
      cidx_q      <= '0;
      side_q      <= 1'b0;
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      cap_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      fill_q      <= fill_d;
      entry_q     <= entry_d;
      cidx_q      <= cidx_d;
      side_q      <= side_d;
      s1_vld_q    <= s1_vld_d;
      s2_vld_q    <= s1_vld_q;
      cap_q       <= s2_vld_q && s2_last_q;
      out_valid_q <= out_valid_d;
    end
  end

  // Pipeline tags and payload
  always_ff @(posedge clk_i) begin
    s1_first_q <= (cidx_q == PTR_LAST);
    s1_last_q  <= (cidx_q == '0);
    s1_side_q  <= side_q;
    s1_ok_q    <= (sufs_pkg::FILL_W'(entry_q) < fill_q);
    s1_cidx_q  <= cidx_q;
    s2_first_q <= s1_first_q;
    s2_last_q  <= s1_last_q;
    s2_side_q  <= s1_side_q;
    cap_side_q <= s2_side_q;
    l_gain_q   <= l_gain_d;
    r_gain_q   <= r_gain_d;
    ls_q       <= ls_d;
    rs_q       <= rs_d;
    if (in_acc) begin
      l_raw_q <= left_sample_i;
      r_raw_q <= right_sample_i;
    end
    if (out_load) begin
      o_lf_q  <= l_gain_q;
      o_rf_q  <= r_gain_q;
      o_ls_q  <= filt ? ls_q : '0;
      o_rs_q  <= filt ? rs_q : '0;
      o_c_q   <= full ? sufs_pkg::clip_sum(l_gain_q, r_gain_q, thr_q) : '0;
      o_lfe_q <= full ? sufs_pkg::clip_sum(ls_q, rs_q, thr_q) : '0;
      o_sv_q  <= filt;
      o_clv_q <= full;
    end
  end

  // Delay memory: write the gained pair, read one entry per issue cycle
  assign mem_we    = (state_q == ST_WRITE);
  assign mem_waddr = {cnt_q[0], ptr_q};
  assign mem_wdata = cnt_q[0] ? r_gain_q : l_gain_q;
  assign mem_raddr = {side_q, entry_q};

  sufs_dmem u_dmem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Multiplier operands: gain during the gain step, taps otherwise
  always_comb begin
    if (state_q == ST_GAIN) begin
      mul_a = (cnt_q == '0) ? l_raw_q : r_raw_q;
      mul_b = $signed({{(sufs_pkg::MUL_B_W - sufs_pkg::GAIN_W){1'b0}}, gain_q});
    end else begin
      mul_a = s1_ok_q ? mem_rdata : '0;
      mul_b = sufs_pkg::MUL_B_W'(sufs_pkg::coef_at(s1_cidx_q));
    end
  end

  assign mac_ctl.acc_en  = s2_vld_q;
  assign mac_ctl.acc_clr = s2_first_q;

  sufs_mac u_mac (
    .clk_i   (clk_i),
    .mul_a_i (mul_a),
    .mul_b_i (mul_b),
    .ctl_i   (mac_ctl),
    .prod_o  (prod),
    .acc_o   (acc)
  );

  // Output ports
  assign out_valid_o        = out_valid_q;
  assign left_surround_o    = o_ls_q;
  assign left_front_o       = o_lf_q;
  assign center_out_o       = o_c_q;
  assign right_front_o      = o_rf_q;
  assign right_surround_o   = o_rs_q;
  assign lfe_out_o          = o_lfe_q;
  assign surround_valid_o   = o_sv_q;
  assign center_lfe_valid_o = o_clv_q;

`ifndef SYNTHESIS
  // Center and LFE only ever come with the surround channels
  a_clv_needs_sv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && center_lfe_valid_o |-> surround_valid_o)
    else $error("center/LFE valid without surround valid");

  // Surround and LFE fields read zero while the surround channels are not produced
  a_unproduced_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !surround_valid_o |->
      left_surround_o == '0 && right_surround_o == '0 && lfe_out_o == '0)
    else $error("surround fields not zero while not produced");

  // The write pointer moves only at the end of a delay line write
  a_ptr_moves_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(ptr_q) |-> $past(state_q) == ST_WRITE)
    else $error("write pointer moved outside the write step");

  // Until the line wraps, the pointer tracks the fill count
  a_ptr_tracks_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q != sufs_pkg::FILL_W'(sufs_pkg::TAP_COUNT) |->
      sufs_pkg::FILL_W'(ptr_q) == fill_q)
    else $error("write pointer and fill count disagree");

  // Accumulation happens only while the lines are walked
  a_acc_in_fir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q |-> state_q == ST_FIR)
    else $error("accumulate outside the FIR step");
`endif

endmodule

// ===== tb/tb_stereo_upmix_fir_surround.sv =====
// ----------------------------------------------------------------------------
// tb_stereo_upmix_fir_surround
// Self-checking bench for the stereo upmix block with FIR surround channels.
// ----------------------------------------------------------------------------
// Each stereo request is predicted in the bench: gain with round half up and
// saturation, two 31-tap high-pass delay lines, center and LFE with symmetric
// clipping. Results are checked in order against a queue of predicted mixes.
// A directed table covers register extremes, every output mode and rounding
// corners. Random phases follow, each with its own register setting, random
// gaps on both channels and one long receiver hold that backs up the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_stereo_upmix_fir_surround;

  typedef logic signed [sufs_pkg::SAMPLE_BITS-1:0] smp_t;

  // One result of the block, in port order
  typedef struct packed {
    smp_t ls;
    smp_t lf;
    smp_t c;
    smp_t rf;
    smp_t rs;
    smp_t lfe;
    logic sv;
    logic cv;
  } mix_out_t;

  // Row of the directed table: a register write or a stereo request
  typedef struct packed {
    logic                           is_cfg;
    logic [sufs_pkg::REG_IDX_W-1:0] idx;
    logic [sufs_pkg::PDATA_W-1:0]   val;
    smp_t                           l;
    smp_t                           r;
    logic                           pin;
    smp_t                           pin_l;
    smp_t                           pin_r;
  } stim_row_t;

  localparam longint LIM_HI = (64'sd1 <<< (sufs_pkg::SAMPLE_BITS - 1)) - 64'sd1;
  localparam longint LIM_LO = -LIM_HI - 64'sd1;
  localparam smp_t   S_MAX  = smp_t'(LIM_HI);
  localparam smp_t   S_MIN  = smp_t'(LIM_LO);
  localparam logic [sufs_pkg::THR_W-1:0] THR_MAX = '1;
  // Unused mode code, behaves as stereo passthrough
  localparam logic [sufs_pkg::MODE_W-1:0] MODE_ALIAS = 2'd3;

  localparam int NUM_PHASES = 9;
  localparam int PHASE_ITEMS = 94;
  localparam int PRESS_PHASE = 2;
  localparam int LONG_HOLD = 600;
  localparam int SETTLE = 8;
  localparam int TAIL = 100;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [sufs_pkg::PADDR_W-1:0]   paddr;
  logic [sufs_pkg::PDATA_W-1:0]   pwdata;
  logic [sufs_pkg::PDATA_W-1:0]   prdata;
  logic                           pready;
  logic                           in_valid;
  logic                           in_stall;
  smp_t                           left_smp;
  smp_t                           right_smp;
  logic                           out_valid;
  logic                           out_stall;
  smp_t                           ls_o, lf_o, c_o, rf_o, rs_o, lfe_o;
  logic                           sv_o, cv_o;

  // Bench copy of the registers and the delay lines
  logic [sufs_pkg::GAIN_W-1:0]    gain_q;
  logic [sufs_pkg::MODE_W-1:0]    mode_q;
  logic [sufs_pkg::THR_W-1:0]     thr_q;
  smp_t                           hist_l [sufs_pkg::TAP_COUNT];
  smp_t                           hist_r [sufs_pkg::TAP_COUNT];
  logic [sufs_pkg::PTR_W-1:0]     wp_l;
  logic [sufs_pkg::PTR_W-1:0]     wp_r;

  mix_out_t             exp_mix_q [$];
  stim_row_t            dir_rows [$];
  int unsigned          mism_cnt;
  logic                 tx_idle;
  logic                 rx_idle;
  logic                 hold_req;

  stereo_upmix_fir_surround i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .left_sample_i      (left_smp),
    .right_sample_i     (right_smp),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .left_surround_o    (ls_o),
    .left_front_o       (lf_o),
    .center_out_o       (c_o),
    .right_front_o      (rf_o),
    .right_surround_o   (rs_o),
    .lfe_out_o          (lfe_o),
    .surround_valid_o   (sv_o),
    .center_lfe_valid_o (cv_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard limit on run time
  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Mix predictor
  // --------------------------------------------------------------------------

  function automatic smp_t sat_smp(input longint v);
    if (v > LIM_HI) begin
      return S_MAX;
    end else if (v < LIM_LO) begin
      return S_MIN;
    end
    return smp_t'(v);
  endfunction

  function automatic smp_t clip_thr(input longint v);
    longint t;
    t = longint'(thr_q);
    if (v > t) begin
      return smp_t'(t);
    end else if (v < -t) begin
      return smp_t'(-t);
    end
    return smp_t'(v);
  endfunction

  // High-pass taps, mirrored around the center tap
  function automatic longint hp_tap(input int k);
    int m;
    m = (k > 15) ? 30 - k : k;
    if (k >= 31) begin
      return 0;
    end
    case (m)
      0:  return -78055;
      1:  return -79192;
      2:  return -80279;
      3:  return -81313;
      4:  return -82290;
      5:  return -83205;
      6:  return -84055;
      7:  return -84835;
      8:  return -85540;
      9:  return -86166;
      10: return -86708;
      11: return -87163;
      12: return -87524;
      13: return -87788;
      14: return -87949;
      default: return 8223130;
    endcase
  endfunction

  function automatic logic [sufs_pkg::PTR_W-1:0] ptr_inc(
    input logic [sufs_pkg::PTR_W-1:0] p
  );
    return (int'(p) + 1 >= sufs_pkg::TAP_COUNT) ? '0 : p + 1'b1;
  endfunction

  function automatic smp_t apply_gain(input smp_t s);
    longint prod;
    prod = longint'(s) * longint'(gain_q);
    return sat_smp((prod + (64'sd1 <<< (sufs_pkg::GAIN_FRAC - 1))) >>> sufs_pkg::GAIN_FRAC);
  endfunction

  // Work out the mix for one stereo request and advance the delay lines
  function automatic mix_out_t predict_mix(input smp_t l_in, input smp_t r_in);
    mix_out_t m;
    longint acc_l, acc_r;
    logic [sufs_pkg::PTR_W-1:0] p_l, p_r;
    logic filt, full;
    m = '0;
    m.lf = apply_gain(l_in);
    m.rf = apply_gain(r_in);
    filt = (mode_q == sufs_pkg::MODE_220) || (mode_q == sufs_pkg::MODE_321);
    full = (mode_q == sufs_pkg::MODE_321);
    if (filt) begin
      hist_l[wp_l] = m.lf;
      hist_r[wp_r] = m.rf;
      p_l = ptr_inc(wp_l);
      p_r = ptr_inc(wp_r);
      acc_l = 0;
      acc_r = 0;
      // Oldest entry meets the last tap, newest meets tap zero
      for (int k = sufs_pkg::TAP_COUNT - 1; k >= 0; k--) begin
        acc_l += hp_tap(k) * longint'(hist_l[p_l]);
        acc_r += hp_tap(k) * longint'(hist_r[p_r]);
        p_l = ptr_inc(p_l);
        p_r = ptr_inc(p_r);
      end
      wp_l = p_l;
      wp_r = p_r;
      m.ls = sat_smp((acc_l + (64'sd1 <<< (sufs_pkg::COEF_FRAC - 1))) >>> sufs_pkg::COEF_FRAC);
      m.rs = sat_smp((acc_r + (64'sd1 <<< (sufs_pkg::COEF_FRAC - 1))) >>> sufs_pkg::COEF_FRAC);
    end
    if (full) begin
      m.c   = clip_thr(longint'(m.lf) + longint'(m.rf));
      m.lfe = clip_thr(longint'(m.ls) + longint'(m.rs));
    end
    m.sv = filt;
    m.cv = full;
    return m;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic stim_row_t cfg_row(input logic [sufs_pkg::REG_IDX_W-1:0] idx,
                                        input logic [sufs_pkg::PDATA_W-1:0] val);
    stim_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.val = val;
    return row;
  endfunction

  function automatic stim_row_t pair_row(input smp_t l, input smp_t r);
    stim_row_t row;
    row = '0;
    row.l = l;
    row.r = r;
    return row;
  endfunction

  function automatic stim_row_t pinned_row(input smp_t l, input smp_t r,
                                           input smp_t el, input smp_t er);
    stim_row_t row;
    row = pair_row(l, r);
    row.pin = 1'b1;
    row.pin_l = el;
    row.pin_r = er;
    return row;
  endfunction

  function automatic smp_t rand_smp();
    case ($urandom_range(0, 9))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return smp_t'($signed($urandom_range(0, 511)) - 256);
      3, 4:    return smp_t'($signed($urandom_range(0, 2097151)) - 1048576);
      default: return smp_t'($urandom);
    endcase
  endfunction

  // Present one stereo request, hold it until taken, then queue its mix
  task automatic send_pair(input smp_t l, input smp_t r, input logic pin,
                           input smp_t pin_l, input smp_t pin_r);
    int unsigned gap;
    mix_out_t want;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    left_smp  <= l;
    right_smp <= r;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    want = predict_mix(l, r);
    if (pin) begin
      want.lf = pin_l;
      want.rf = pin_r;
    end
    exp_mix_q.push_back(want);
  endtask

  // Drop valid and let the block empty out before a register write
  task automatic drain();
    in_valid <= 1'b0;
    while (exp_mix_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [sufs_pkg::REG_IDX_W-1:0] idx,
                           input logic [sufs_pkg::PDATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= sufs_pkg::PADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      sufs_pkg::REG_GAIN: gain_q = val[sufs_pkg::GAIN_W-1:0];
      sufs_pkg::REG_MODE: mode_q = val[sufs_pkg::MODE_W-1:0];
      sufs_pkg::REG_CLIP: thr_q  = val[sufs_pkg::THR_W-1:0];
      default: ;
    endcase
    // Leave the bus idle between accesses
    @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Result checker and receiver stall
  // --------------------------------------------------------------------------

  initial begin : result_side
    int unsigned hold_left;
    logic hold_seen;
    mix_out_t got, want;
    hold_left = 0;
    hold_seen = 1'b0;
    mism_cnt  = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid && !out_stall) begin
        got = '{ls_o, lf_o, c_o, rf_o, rs_o, lfe_o, sv_o, cv_o};
        if (exp_mix_q.size() == 0) begin
          mism_cnt++;
          if (mism_cnt <= 10) begin
            $display("%0t: unexpected result ls=%0d lf=%0d c=%0d rf=%0d rs=%0d lfe=%0d",
                     $realtime, got.ls, got.lf, got.c, got.rf, got.rs, got.lfe);
          end
        end else begin
          want = exp_mix_q.pop_front();
          if (got !== want) begin
            mism_cnt++;
            if (mism_cnt <= 10) begin
              $display("%0t: mix mismatch", $realtime);
              $display("  exp ls=%0d lf=%0d c=%0d rf=%0d rs=%0d lfe=%0d sv=%b cv=%b",
                       want.ls, want.lf, want.c, want.rf, want.rs, want.lfe,
                       want.sv, want.cv);
              $display("  got ls=%0d lf=%0d c=%0d rf=%0d rs=%0d lfe=%0d sv=%b cv=%b",
                       got.ls, got.lf, got.c, got.rf, got.rs, got.lfe, got.sv, got.cv);
            end
          end
        end
        hold_left = rx_idle ? $urandom_range(0, 15) : 0;
      end
      // Long hold so the block backs up into its input
      if (hold_req && !hold_seen) begin
        hold_left = LONG_HOLD;
        hold_seen = 1'b1;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  initial begin : request_side
    stim_row_t row;
    smp_t l, r, hold_l, hold_r;
    int unsigned pat;
    logic flip;
    logic [sufs_pkg::MODE_W-1:0] ph_mode;
    logic [sufs_pkg::PDATA_W-1:0] g, t;

    rst_ni    <= 1'b0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    in_valid  <= 1'b0;
    left_smp  <= '0;
    right_smp <= '0;
    tx_idle   <= 1'b1;
    rx_idle   <= 1'b1;
    hold_req  <= 1'b0;
    gain_q    = sufs_pkg::GAIN_RST;
    mode_q    = sufs_pkg::MODE_RST;
    thr_q     = sufs_pkg::CLIP_RST;
    wp_l      = '0;
    wp_r      = '0;
    for (int i = 0; i < sufs_pkg::TAP_COUNT; i++) begin
      hist_l[i] = '0;
      hist_r[i] = '0;
    end

    // Directed table: reset state, gain extremes and rounding, clip, modes
    dir_rows.push_back(pinned_row(0, 0, 0, 0));
    dir_rows.push_back(pinned_row(S_MAX, S_MAX, S_MAX, S_MAX));
    dir_rows.push_back(pinned_row(S_MIN, S_MIN, S_MIN, S_MIN));
    dir_rows.push_back(pinned_row(S_MAX, S_MIN, S_MAX, S_MIN));
    dir_rows.push_back(pinned_row(1, -1, 1, -1));
    dir_rows.push_back(cfg_row(sufs_pkg::REG_GAIN, 32'd65535));
    dir_rows.push_back(pinned_row(S_MAX, S_MIN, S_MAX, S_MIN));
    dir_rows.push_back(pinned_row(1, -1, 4, -4));
    dir_rows.push_back(cfg_row(sufs_pkg::REG_GAIN, 32'd0));
    dir_rows.push_back(pinned_row(S_MAX, S_MIN, 0, 0));
    dir_rows.push_back(cfg_row(sufs_pkg::REG_GAIN, 32'd8192));
    dir_rows.push_back(pinned_row(1, -1, 1, 0));
    dir_rows.push_back(pinned_row(3, -3, 2, -1));
    dir_rows.push_back(cfg_row(sufs_pkg::REG_GAIN, 32'd16384));
    dir_rows.push_back(pair_row(S_MAX, S_MIN));
    dir_rows.push_back(pair_row(S_MIN, S_MAX));
    dir_rows.push_back(pair_row(S_MAX, S_MIN));
    dir_rows.push_back(pair_row(S_MIN, S_MAX));
    dir_rows.push_back(cfg_row(sufs_pkg::REG_CLIP, 32'd0));
    dir_rows.push_back(pair_row(4660, -2000));
    dir_rows.push_back(cfg_row(sufs_pkg::REG_CLIP, 32'd1000));
    dir_rows.push_back(pair_row(S_MAX, S_MAX));
    dir_rows.push_back(pair_row(-5000, -7000));
    dir_rows.push_back(cfg_row(sufs_pkg::REG_MODE, 32'(sufs_pkg::MODE_220)));
    dir_rows.push_back(pinned_row(100, 200, 100, 200));
    dir_rows.push_back(pair_row(S_MIN, S_MAX));
    dir_rows.push_back(cfg_row(sufs_pkg::REG_MODE, 32'(sufs_pkg::MODE_STEREO)));
    dir_rows.push_back(pinned_row(S_MAX, -1, S_MAX, -1));
    dir_rows.push_back(cfg_row(sufs_pkg::REG_MODE, 32'(MODE_ALIAS)));
    dir_rows.push_back(pinned_row(5, 6, 5, 6));
    dir_rows.push_back(cfg_row(sufs_pkg::REG_MODE, 32'(sufs_pkg::MODE_321)));
    dir_rows.push_back(cfg_row(sufs_pkg::REG_CLIP, 32'(THR_MAX)));
    dir_rows.push_back(pair_row(smp_t'(24'h123456), -smp_t'(24'h123456)));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.is_cfg) begin
        drain();
        write_reg(row.idx, row.val);
      end else begin
        send_pair(row.l, row.r, row.pin, row.pin_l, row.pin_r);
      end
    end

    // Random phases, each with fresh register values
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      case (ph)
        1, 5:    ph_mode = sufs_pkg::MODE_220;
        3:       ph_mode = sufs_pkg::MODE_STEREO;
        6:       ph_mode = MODE_ALIAS;
        default: ph_mode = sufs_pkg::MODE_321;
      endcase
      case ($urandom_range(0, 3))
        0:       g = 32'd16384;
        1:       g = $urandom_range(12000, 24000);
        default: g = $urandom_range(0, 65535);
      endcase
      case ($urandom_range(0, 3))
        0:       t = 32'(THR_MAX);
        1:       t = $urandom_range(0, 4095);
        default: t = $urandom_range(0, 8388607);
      endcase
      write_reg(sufs_pkg::REG_GAIN, g);
      write_reg(sufs_pkg::REG_MODE, 32'(ph_mode));
      write_reg(sufs_pkg::REG_CLIP, t);
      tx_idle <= (ph != PRESS_PHASE) && ($urandom_range(0, 3) != 0);
      rx_idle <= $urandom_range(0, 3) != 0;
      if (ph == PRESS_PHASE) begin
        hold_req <= 1'b1;
      end
      pat = 0;
      flip = 1'b0;
      hold_l = '0;
      hold_r = '0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Pick a signal shape every 24 requests
        if (n % 24 == 0) begin
          pat = $urandom_range(0, 3);
          flip = 1'($urandom_range(0, 1));
          hold_l = rand_smp();
          hold_r = rand_smp();
        end
        case (pat)
          2: begin
            l = n[0] ? S_MAX : S_MIN;
            r = (n[0] ^ flip) ? S_MAX : S_MIN;
          end
          3: begin
            l = hold_l;
            r = hold_r;
          end
          default: begin
            l = rand_smp();
            r = rand_smp();
          end
        endcase
        send_pair(l, r, 1'b0, '0, '0);
      end
    end

    // Wait for the last results, then a tail for stray ones
    in_valid <= 1'b0;
    while (exp_mix_q.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);
    if (mism_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
